@@ rtl/rnf_pkg.sv @@
// Shared types and constants of the radius neighbor filter.
`timescale 1ns / 1ps
package rnf_pkg;

  localparam int RADIUS_W = 23;
  localparam int SQ_W     = 2 * RADIUS_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int ID_W     = 32;
  localparam int REQ_W    = 2;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

  typedef struct packed {
    logic clear;
    logic load;
    logic capture;
  } cell_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             ok;
    logic [SUM_W-1:0] sum;
  } link_t;

endpackage

@@ rtl/rnf_in_if.sv @@
// Request channel: valid/ready handshake with target or query payload.
`timescale 1ns / 1ps
interface rnf_in_if #(
  parameter int COORD_BITS = 24
);
  logic                         valid;
  logic                         ready;
  logic [rnf_pkg::REQ_W-1:0]    req_type;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  logic [rnf_pkg::ID_W-1:0]     point_id;
  logic                         last_query;

  modport source (output valid, req_type, coord_x, coord_y, coord_z, point_id, last_query,
                  input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, coord_z, point_id, last_query,
                  output ready);
endinterface

@@ rtl/rnf_out_if.sv @@
// Result channel: valid/ready handshake with query result payload.
`timescale 1ns / 1ps
interface rnf_out_if;
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic [rnf_pkg::ID_W-1:0] result_id;
  logic                     last;
  logic                     overflow;

  modport source (output valid, hit, result_id, last, overflow, input ready);
  modport sink   (input valid, hit, result_id, last, overflow, output ready);
endinterface

@@ rtl/radius_neighbor_filter.sv @@
// Radius neighbor filter top level: request control, cell chain and result register.
// Loads and clears are taken in the idle state. A query point is tested against the target
// bounding box grown by the radius in the cycle after it is taken; a point outside,
// or any point when the store is empty, misses at once. Otherwise the stored targets
// are scanned in load order, one per cycle, through a chain of three axis cells
// (x, y, z), each reading its own axis memory and adding one squared term. The scan
// stops issuing at the first hit, and the chain drains before the result is posted;
// at most the number stored, up to MAX_TARGETS, are read. Requests, queries too, are
// still taken while a posted result waits at the output.
`timescale 1ns / 1ps
module radius_neighbor_filter #(
  parameter int MAX_TARGETS = 1024,
  parameter int COORD_BITS  = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rnf_in_if.sink                           in_ch,
  rnf_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [rnf_pkg::RADIUS_W-1:0]     cfg_wdata
);
  localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CW = $clog2(MAX_TARGETS + 1);
  localparam int NCELL = 3;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0]                  count_r, scan_idx_r;
  logic                           dropped_r;
  logic [rnf_pkg::RADIUS_W-1:0]   radius_r;
  logic [rnf_pkg::SQ_W-1:0]       rr_r;
  logic                           hit_seen_r;
  logic [rnf_pkg::ID_W-1:0]       qid_r;
  logic                           qlast_r;

  logic                           out_valid_r, out_hit_r, out_last_r, out_ovf_r;
  logic [rnf_pkg::ID_W-1:0]       out_id_r;

  logic                           accept, full, issue, busy_any, in_box_all;
  logic                           hit_now, scan_done, out_free;
  rnf_pkg::cell_ctl_t             cell_ctl;
  rnf_pkg::link_t                 links [NCELL+1];
  logic [AW-1:0]                  addrs [NCELL+1];
  logic [NCELL-1:0]               busy, in_box;
  logic signed [COORD_BITS-1:0]   coords [NCELL];

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CW'(MAX_TARGETS));

  always_comb begin
    cell_ctl = '0;
    if (accept) begin
      unique case (in_ch.req_type)
        rnf_pkg::REQ_CLEAR: cell_ctl.clear   = 1'b1;
        rnf_pkg::REQ_LOAD:  cell_ctl.load    = !full;
        rnf_pkg::REQ_QUERY: cell_ctl.capture = 1'b1;
        default:            cell_ctl = '0;
      endcase
    end
  end

  assign coords[0] = in_ch.coord_x;
  assign coords[1] = in_ch.coord_y;
  assign coords[2] = in_ch.coord_z;

  assign hit_now   = links[NCELL].valid && links[NCELL].ok &&
                     (links[NCELL].sum <= rnf_pkg::SUM_W'(rr_r));
  assign issue     = (state_r == ST_SCAN) && !hit_seen_r && !hit_now &&
                     (scan_idx_r < count_r);
  assign scan_done = (hit_seen_r || (scan_idx_r >= count_r)) && !busy_any;
  assign busy_any  = |busy;
  assign in_box_all = &in_box;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign links[0].valid = issue;
  assign links[0].ok    = 1'b1;
  assign links[0].sum   = '0;
  assign addrs[0]       = scan_idx_r[AW-1:0];

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    rnf_cell #(
      .COORD_BITS (COORD_BITS),
      .MAX_TARGETS(MAX_TARGETS),
      .AW         (AW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (cell_ctl),
      .coord_in(coords[g]),
      .wr_addr (count_r[AW-1:0]),
      .radius  (radius_r),
      .link_in (links[g]),
      .addr_in (addrs[g]),
      .link_out(links[g+1]),
      .addr_out(addrs[g+1]),
      .in_box  (in_box[g]),
      .busy    (busy[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (cell_ctl.capture) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = in_box_all ? ST_SCAN : ST_RESULT;
      ST_SCAN:   if (scan_done) state_nxt = ST_RESULT;
      ST_RESULT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      radius_r    <= '0;
      hit_seen_r  <= 1'b0;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
      if (cell_ctl.clear) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
      end else if (cell_ctl.load) begin
        count_r <= count_r + CW'(1);
      end else if (accept && in_ch.req_type == rnf_pkg::REQ_LOAD) begin
        dropped_r <= 1'b1;
      end
      if (cell_ctl.capture) begin
        hit_seen_r <= 1'b0;
        scan_idx_r <= '0;
      end else begin
        if (state_r == ST_SCAN && hit_now) begin
          hit_seen_r <= 1'b1;
        end
        if (issue) begin
          scan_idx_r <= scan_idx_r + CW'(1);
        end
      end
      if (state_r == ST_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rr_r <= radius_r * radius_r;
    if (cell_ctl.capture) begin
      qid_r   <= in_ch.point_id;
      qlast_r <= in_ch.last_query;
    end
    if (state_r == ST_RESULT && out_free) begin
      out_hit_r  <= hit_seen_r;
      out_id_r   <= qid_r;
      out_last_r <= qlast_r;
      out_ovf_r  <= dropped_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.result_id = out_id_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.overflow  = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TARGETS))
    else $error("target count beyond capacity");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT) |-> !busy_any)
    else $error("result posted while the cell chain still busy");

  a_post_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result appeared outside the result state");

  a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && hit_seen_r) |=> !issue)
    else $error("scan kept issuing after a hit");
endmodule

@@ rtl/rnf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rnf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

@@ rtl/rnf_cell.sv @@
// One axis cell: axis target store, axis box bounds and one term of the distance sum.
`timescale 1ns / 1ps
module rnf_cell #(
  parameter int COORD_BITS  = 24,
  parameter int MAX_TARGETS = 1024,
  parameter int AW          = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rnf_pkg::cell_ctl_t               ctl,
  input  logic signed [COORD_BITS-1:0]     coord_in,
  input  logic [AW-1:0]                    wr_addr,
  input  logic [rnf_pkg::RADIUS_W-1:0]     radius,
  input  rnf_pkg::link_t                   link_in,
  input  logic [AW-1:0]                    addr_in,
  output rnf_pkg::link_t                   link_out,
  output logic [AW-1:0]                    addr_out,
  output logic                             in_box,
  output logic                             busy
);
  localparam int RW     = rnf_pkg::RADIUS_W;
  localparam int CMP_W  = (COORD_BITS > RW) ? COORD_BITS : RW;
  localparam int EXT_W  = CMP_W + 2;
  localparam logic signed [COORD_BITS-1:0] MAXPOS = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] MAXNEG = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS-1:0] box_low_r, box_high_r, q_r;
  logic [COORD_BITS-1:0]        rd_data;

  rnf_pkg::link_t      s1_link_r, s2_link_r, s3_link_r, out_link_r;
  logic [AW-1:0]       s1_addr_r, s2_addr_r, s3_addr_r, out_addr_r;
  logic [RW-1:0]       s2_d_r;
  logic [rnf_pkg::SQ_W-1:0] s3_sq_r;

  logic signed [COORD_BITS:0]   diff;
  logic [COORD_BITS-1:0]        mag;
  logic [CMP_W-1:0]             mag_ext;
  logic                         in_range;

  logic signed [EXT_W-1:0] q_ext, lo_ext, hi_ext, r_ext;

  rnf_ram #(
    .WIDTH(COORD_BITS),
    .DEPTH(MAX_TARGETS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ctl.load),
    .wr_addr(wr_addr),
    .wr_data(coord_in),
    .rd_addr(addr_in),
    .rd_data(rd_data)
  );

  // box and held query coordinate
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      box_low_r  <= MAXPOS;
      box_high_r <= MAXNEG;
    end else if (ctl.load) begin
      if (coord_in < box_low_r) begin
        box_low_r <= coord_in;
      end
      if (coord_in > box_high_r) begin
        box_high_r <= coord_in;
      end
    end
    if (ctl.capture) begin
      q_r <= coord_in;
    end
  end

  assign q_ext  = EXT_W'(q_r);
  assign r_ext  = EXT_W'(radius);
  assign lo_ext = EXT_W'(box_low_r) - r_ext;
  assign hi_ext = EXT_W'(box_high_r) + r_ext;
  assign in_box = (q_ext >= lo_ext) && (q_ext <= hi_ext);

  // axis distance term
  assign diff     = {q_r[COORD_BITS-1], q_r} - {rd_data[COORD_BITS-1], rd_data};
  assign mag      = diff[COORD_BITS] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
  assign mag_ext  = CMP_W'(mag);
  assign in_range = mag_ext <= CMP_W'(radius);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_link_r.valid  <= 1'b0;
      s2_link_r.valid  <= 1'b0;
      s3_link_r.valid  <= 1'b0;
      out_link_r.valid <= 1'b0;
    end else begin
      s1_link_r.valid  <= link_in.valid;
      s2_link_r.valid  <= s1_link_r.valid;
      s3_link_r.valid  <= s2_link_r.valid;
      out_link_r.valid <= s3_link_r.valid;
    end
    s1_link_r.ok  <= link_in.ok;
    s1_link_r.sum <= link_in.sum;
    s1_addr_r     <= addr_in;

    s2_link_r.ok  <= s1_link_r.ok && in_range;
    s2_link_r.sum <= s1_link_r.sum;
    s2_addr_r     <= s1_addr_r;
    s2_d_r        <= mag_ext[RW-1:0];

    s3_link_r.ok  <= s2_link_r.ok;
    s3_link_r.sum <= s2_link_r.sum;
    s3_addr_r     <= s2_addr_r;
    s3_sq_r       <= s2_d_r * s2_d_r;

    out_link_r.ok  <= s3_link_r.ok;
    out_link_r.sum <= s3_link_r.sum + rnf_pkg::SUM_W'(s3_sq_r);
    out_addr_r     <= s3_addr_r;
  end

  assign link_out = out_link_r;
  assign addr_out = out_addr_r;
  assign busy     = s1_link_r.valid | s2_link_r.valid | s3_link_r.valid | out_link_r.valid;
endmodule

@@ sim/radius_neighbor_filter_checker.sv @@
// Scoreboard for the radius neighbor filter: tracks targets and radius, predicts and checks results.
`timescale 1ns / 1ps
module radius_neighbor_filter_checker #(
  parameter int MAX_TARGETS = 1024,
  parameter int COORD_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  rnf_in_if                            in_mon,
  rnf_out_if                           out_mon,
  input  logic                         cfg_we,
  input  logic [rnf_pkg::RADIUS_W-1:0] cfg_wdata,
  output int                           fail_count,
  output int                           pending
);

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS - 1));

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                     hit;
    logic [rnf_pkg::ID_W-1:0] id;
    logic                     last;
    logic                     overflow;
  } query_result_t;

  coord_t        tgt_x [MAX_TARGETS];
  coord_t        tgt_y [MAX_TARGETS];
  coord_t        tgt_z [MAX_TARGETS];
  int unsigned   tgt_count;
  longint        box_lo [3];
  longint        box_hi [3];
  logic          dropped;
  longint        radius_q;
  query_result_t awaited[$];

  function automatic void empty_store();
    tgt_count = 0;
    dropped   = 1'b0;
    for (int k = 0; k < 3; k++) begin
      box_lo[k] = COORD_MAX;
      box_hi[k] = COORD_MIN;
    end
  endfunction

  function automatic longint axis_gap(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // per-axis bound first, so the sum never grows past three radius squares
  function automatic bit target_in_reach(longint px, longint py, longint pz, int unsigned j);
    longint d [3];
    longint acc;
    d[0] = axis_gap(px, tgt_x[j]);
    d[1] = axis_gap(py, tgt_y[j]);
    d[2] = axis_gap(pz, tgt_z[j]);
    acc  = 0;
    for (int k = 0; k < 3; k++) begin
      if (d[k] > radius_q) return 1'b0;
      acc += d[k] * d[k];
    end
    return acc <= radius_q * radius_q;
  endfunction

  function automatic bit any_target_near(longint px, longint py, longint pz);
    longint p [3];
    p[0] = px;
    p[1] = py;
    p[2] = pz;
    for (int k = 0; k < 3; k++) begin
      if (p[k] < box_lo[k] - radius_q || p[k] > box_hi[k] + radius_q) return 1'b0;
    end
    for (int unsigned j = 0; j < tgt_count; j++) begin
      if (target_in_reach(px, py, pz, j)) return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    query_result_t want;
    query_result_t got;
    longint        px;
    longint        py;
    longint        pz;
    if (!rst_n) begin
      radius_q   = 0;
      fail_count = 0;
      empty_store();
      awaited.delete();
    end else begin
      if (cfg_we) radius_q = longint'(cfg_wdata);

      if (out_mon.valid && out_mon.ready) begin
        got = '{hit: out_mon.hit, id: out_mon.result_id, last: out_mon.last,
                overflow: out_mon.overflow};
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result: hit=%0b id=%08h last=%0b overflow=%0b",
                   $time, got.hit, got.id, got.last, got.overflow);
          fail_count++;
        end else begin
          want = awaited.pop_front();
          if (got.hit !== want.hit || got.id !== want.id || got.last !== want.last ||
              got.overflow !== want.overflow) begin
            $display("%0t: mismatch: expected %0b/%08h/%0b/%0b, got %0b/%08h/%0b/%0b",
                     $time, want.hit, want.id, want.last, want.overflow,
                     got.hit, got.id, got.last, got.overflow);
            fail_count++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        px = in_mon.coord_x;
        py = in_mon.coord_y;
        pz = in_mon.coord_z;
        case (in_mon.req_type)
          rnf_pkg::REQ_CLEAR: empty_store();
          rnf_pkg::REQ_LOAD: begin
            if (tgt_count >= MAX_TARGETS) begin
              dropped = 1'b1;
            end else begin
              tgt_x[tgt_count] = in_mon.coord_x;
              tgt_y[tgt_count] = in_mon.coord_y;
              tgt_z[tgt_count] = in_mon.coord_z;
              tgt_count++;
              if (px < box_lo[0]) box_lo[0] = px;
              if (px > box_hi[0]) box_hi[0] = px;
              if (py < box_lo[1]) box_lo[1] = py;
              if (py > box_hi[1]) box_hi[1] = py;
              if (pz < box_lo[2]) box_lo[2] = pz;
              if (pz > box_hi[2]) box_hi[2] = pz;
            end
          end
          rnf_pkg::REQ_QUERY: begin
            want = '{hit: any_target_near(px, py, pz), id: in_mon.point_id,
                     last: in_mon.last_query, overflow: dropped};
            awaited = {awaited, want};
          end
          default: ;
        endcase
      end
    end
    pending = awaited.size();
  end

endmodule

@@ sim/radius_neighbor_filter_tb.sv @@
// Testbench top for the radius neighbor filter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module radius_neighbor_filter_tb;

  localparam int             COORD_W       = 24;
  localparam int             MAX_TARGETS   = 1024;
  localparam logic [rnf_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;
  localparam longint         COORD_HI      = 8388607;
  localparam longint         COORD_LO      = -8388608;
  localparam longint         RADIUS_MAX    = 8388607;
  localparam int             RANDOM_ITEMS  = 580;
  localparam int             SETTLE_CYCLES = 24;
  localparam int             DRAIN_CYCLES  = 40;
  localparam int             HALF_PERIOD   = 4;
  localparam time            RUN_LIMIT     = 40_000_000;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } point_t;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         cfg_we    = 1'b0;
  logic [rnf_pkg::RADIUS_W-1:0] cfg_wdata = '0;
  logic                         rcv_ready = 1'b0;
  int                  snd_idle_pct = 0;
  int                  rcv_idle_pct = 0;
  int                  items_sent   = 0;
  int                  fail_count;
  int                  pending;
  point_t              loaded[$];

  rnf_in_if #(.COORD_BITS(COORD_W)) in_ch ();
  rnf_out_if                        out_ch ();

  assign out_ch.ready = rcv_ready;

  radius_neighbor_filter #(
    .MAX_TARGETS(MAX_TARGETS),
    .COORD_BITS (COORD_W)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  radius_neighbor_filter_checker #(
    .MAX_TARGETS(MAX_TARGETS),
    .COORD_BITS (COORD_W)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  always @(negedge clk) begin
    rcv_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  initial begin
    #RUN_LIMIT;
    $display("[radius_neighbor_filter] ERROR");
    $finish;
  end

  function automatic longint clip(longint v);
    return (v < COORD_LO) ? COORD_LO : ((v > COORD_HI) ? COORD_HI : v);
  endfunction

  function automatic longint rand_coord();
    logic signed [COORD_W-1:0] v;
    v = COORD_W'($urandom);
    return v;
  endfunction

  function automatic longint jitter(longint c, longint span);
    longint off;
    off = longint'($urandom_range(32'(2 * span))) - span;
    return clip(c + off);
  endfunction

  function automatic longint edge_coord();
    case ($urandom_range(2))
      0:       return COORD_LO;
      1:       return COORD_HI;
      default: return 0;
    endcase
  endfunction

  task automatic send(input logic [rnf_pkg::REQ_W-1:0] req, input longint x,
                      input longint y, input longint z,
                      input logic [rnf_pkg::ID_W-1:0] id, input logic lastq);
    point_t pt;
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.coord_x    <= x[COORD_W-1:0];
    in_ch.coord_y    <= y[COORD_W-1:0];
    in_ch.coord_z    <= z[COORD_W-1:0];
    in_ch.point_id   <= id;
    in_ch.last_query <= lastq;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (req == rnf_pkg::REQ_CLEAR) loaded.delete();
    if (req == rnf_pkg::REQ_LOAD) begin
      pt     = '{x, y, z};
      loaded = {loaded, pt};
    end
    if (req != REQ_SPARE) items_sent++;
  endtask

  task automatic query(input longint x, input longint y, input longint z);
    send(rnf_pkg::REQ_QUERY, x, y, z, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic load(input longint x, input longint y, input longint z);
    send(rnf_pkg::REQ_LOAD, x, y, z, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic send_bare(input logic [rnf_pkg::REQ_W-1:0] req);
    send(req, rand_coord(), rand_coord(), rand_coord(), $urandom, 1'($urandom_range(1)));
  endtask

  // hold the sender until every result is back and loads have drained
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_radius(input longint r);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r[rnf_pkg::RADIUS_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input bit hold_mid);
    int     n;
    int     m;
    int     roll;
    longint span;
    longint r;
    longint reach;
    longint cx;
    longint cy;
    longint cz;
    point_t t;
    span = longint'(1) << $urandom_range(23, 4);
    case ($urandom_range(9))
      0:       r = 0;
      1:       r = RADIUS_MAX;
      default: r = longint'($urandom_range(32'(span)));
    endcase
    if (r > RADIUS_MAX) r = RADIUS_MAX;
    set_radius(r);
    reach = (r > 0) ? r : 1;
    cx = rand_coord();
    cy = rand_coord();
    cz = rand_coord();
    if ($urandom_range(3) != 0) send_bare(rnf_pkg::REQ_CLEAR);
    n = $urandom_range(20);
    repeat (n) load(jitter(cx, span), jitter(cy, span), jitter(cz, span));
    m = $urandom_range(14, 4);
    for (int q = 0; q < m; q++) begin
      if (hold_mid && q == m / 2) settle();
      roll = $urandom_range(99);
      if (roll < 3) send_bare(REQ_SPARE);
      else if (roll < 5) send_bare(rnf_pkg::REQ_CLEAR);
      else if (roll < 13) load(jitter(cx, span), jitter(cy, span), jitter(cz, span));
      roll = $urandom_range(99);
      if (loaded.size() != 0 && roll < 55) begin
        t = loaded[$urandom_range(loaded.size() - 1)];
        if (roll < 8) query(t.x, t.y, t.z);
        else query(jitter(t.x, reach), jitter(t.y, reach), jitter(t.z, reach));
      end else if (roll < 80) begin
        query(jitter(cx, span), jitter(cy, span), jitter(cz, span));
      end else if (roll < 92) begin
        query(rand_coord(), rand_coord(), rand_coord());
      end else begin
        query(edge_coord(), edge_coord(), edge_coord());
      end
    end
  endtask

  initial begin
    int     phase_no;
    int     stage;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = rnf_pkg::REQ_CLEAR;
    in_ch.coord_x    = '0;
    in_ch.coord_y    = '0;
    in_ch.coord_z    = '0;
    in_ch.point_id   = '0;
    in_ch.last_query = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty store, corners, zero radius, inclusive boundary
    query(0, 0, 0);
    send(rnf_pkg::REQ_QUERY, COORD_HI, COORD_HI, COORD_HI, '1, 1'b1);
    send(REQ_SPARE, COORD_LO, COORD_LO, COORD_LO, '1, 1'b1);
    load(COORD_LO, COORD_LO, COORD_LO);
    load(COORD_HI, COORD_HI, COORD_HI);
    send(rnf_pkg::REQ_QUERY, COORD_LO, COORD_LO, COORD_LO, '0, 1'b0);
    query(COORD_HI, COORD_HI, COORD_HI - 1);
    query(0, 0, 0);
    set_radius(RADIUS_MAX);
    query(-1, COORD_LO, COORD_LO);
    query(-1, -1, -1);
    query(0, 0, 0);
    send_bare(rnf_pkg::REQ_CLEAR);
    query(-1, COORD_LO, COORD_LO);
    set_radius(768);
    load(0, 0, 0);
    query(768, 0, 0);
    query(769, 0, 0);
    query(443, 443, -443);
    query(444, -444, 444);
    query(0, 0, -769);

    items_sent = 0;
    phase_no   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      stage = items_sent * 3 / RANDOM_ITEMS;
      case (stage)
        0:       begin snd_idle_pct = 23; rcv_idle_pct = 63; end
        1:       begin snd_idle_pct = 63; rcv_idle_pct = 23; end
        default: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
      endcase
      run_phase(phase_no % 6 == 3);
      phase_no++;
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[radius_neighbor_filter] OK");
    end else begin
      $display("[radius_neighbor_filter] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rnf_pkg.sv
rtl/rnf_in_if.sv
rtl/rnf_out_if.sv
rtl/rnf_ram.sv
rtl/rnf_cell.sv
rtl/radius_neighbor_filter.sv
sim/radius_neighbor_filter_checker.sv
sim/radius_neighbor_filter_tb.sv
